/* sv/spi_pkg.sv */
// ----------------------------------------------------------------------------
// spi_pkg
// Shared types and constants of the spectrum peak interpolator.
// ----------------------------------------------------------------------------
package spi_pkg;

	localparam int MAX_HALF_BINS = 4096;
	localparam int MAG_W         = 24;
	localparam int CNT_W         = $clog2(MAX_HALF_BINS + 1);
	localparam int IDX_W         = 13;
	localparam int POS_W         = 28;
	localparam int FREQ_W        = 48;
	localparam int AMP_W         = MAG_W + 1;
	localparam int SPACING_W     = 32;
	localparam int FRAC_W        = 15;
	localparam int HALF_Q15      = 1 << (FRAC_W - 1);
	localparam int DIFF_W        = MAG_W + 1;
	localparam int DEN_W         = MAG_W + 3;
	localparam int DELTA_W       = FRAC_W + 1;
	localparam int QUO_W         = FRAC_W;
	localparam int REM_W         = DEN_W + QUO_W;
	localparam int PROD_W        = POS_W + SPACING_W;
	localparam int APROD_W       = DIFF_W + DELTA_W;
	localparam int AMP_SHIFT     = FRAC_W + 2;
	localparam int QDEPTH        = 2;
	localparam int QPTR_W        = $clog2(QDEPTH);
	localparam int OUT_DATA_W    = 120;

	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   bin;
		logic [MAG_W-1:0]   left;
		logic [MAG_W-1:0]   peak;
		logic [MAG_W-1:0]   right;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* sv/spi_front.sv */
// ----------------------------------------------------------------------------
// spi_front
// Bin tracker: counts bins, keeps the running maximum and its neighbors,
// and issues one job per spectrum on the last bin.
// ----------------------------------------------------------------------------
module spi_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [spi_pkg::MAG_W-1:0]   magnitude,
	input  logic                        last,
	output logic                        push,
	output spi_pkg::job_t               job
);

	logic [spi_pkg::CNT_W-1:0] bin_counter_q;
	logic [spi_pkg::MAG_W-1:0] previous_mag_q;
	logic [spi_pkg::MAG_W-1:0] best_mag_q;
	logic [spi_pkg::IDX_W-1:0] best_bin_q;
	logic [spi_pkg::MAG_W-1:0] left_q;
	logic [spi_pkg::MAG_W-1:0] right_q;
	logic                      await_right_q;
	logic                      candidate;

	assign candidate = !last && (bin_counter_q >= spi_pkg::CNT_W'(1))
		&& (bin_counter_q < spi_pkg::CNT_W'(spi_pkg::MAX_HALF_BINS))
		&& ((bin_counter_q == spi_pkg::CNT_W'(1)) || (magnitude > best_mag_q));

	assign push        = accept && last;
	assign job.found   = bin_counter_q >= spi_pkg::CNT_W'(2);
	assign job.bin     = best_bin_q;
	assign job.left    = left_q;
	assign job.peak    = best_mag_q;
	assign job.right   = await_right_q ? magnitude : right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_counter_q  <= '0;
			previous_mag_q <= '0;
			best_mag_q     <= '0;
			best_bin_q     <= '0;
			left_q         <= '0;
			right_q        <= '0;
			await_right_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				bin_counter_q  <= '0;
				previous_mag_q <= '0;
				best_mag_q     <= '0;
				best_bin_q     <= '0;
				left_q         <= '0;
				right_q        <= '0;
				await_right_q  <= 1'b0;
			end else begin
				if (await_right_q) begin
					right_q <= magnitude;
				end
				await_right_q <= candidate;
				if (candidate) begin
					best_mag_q <= magnitude;
					best_bin_q <= spi_pkg::IDX_W'(bin_counter_q);
					left_q     <= previous_mag_q;
				end
				previous_mag_q <= magnitude;
				if (bin_counter_q < spi_pkg::CNT_W'(spi_pkg::MAX_HALF_BINS)) begin
					bin_counter_q <= bin_counter_q + spi_pkg::CNT_W'(1);
				end
			end
		end
	end

endmodule

/* sv/spi_queue.sv */
// ----------------------------------------------------------------------------
// spi_queue
// Two-entry job queue between the bin tracker and the interpolation engine.
// ----------------------------------------------------------------------------
module spi_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  spi_pkg::job_t       push_data,
	input  logic                pop,
	output spi_pkg::job_t       pop_data,
	output spi_pkg::q_status_t  status
);

	spi_pkg::job_t                 mem_q [spi_pkg::QDEPTH];
	logic [spi_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [spi_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [spi_pkg::QPTR_W:0]      count_q;
	logic                          do_push;
	logic                          do_pop;

	assign status.full  = count_q == (spi_pkg::QPTR_W+1)'(spi_pkg::QDEPTH);
	assign status.empty = count_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + spi_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + spi_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (spi_pkg::QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (spi_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

/* sv/spi_back.sv */
// ----------------------------------------------------------------------------
// spi_back
// Interpolation engine: parabolic vertex offset through a serial divider,
// position, frequency and amplitude, into the output word register.
// ----------------------------------------------------------------------------
module spi_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  spi_pkg::job_t                   q_data,
	output logic                            q_pop,
	input  logic [spi_pkg::SPACING_W-1:0]   bin_spacing,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [spi_pkg::IDX_W-1:0]       peak_index,
	output logic [spi_pkg::POS_W-1:0]       peak_position,
	output logic [spi_pkg::FREQ_W-1:0]      peak_freq,
	output logic [spi_pkg::AMP_W-1:0]       peak_amplitude
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_CHECK,
		S_DIV,
		S_POS,
		S_MUL,
		S_DONE
	} state_t;

	localparam int STEP_W = $clog2(spi_pkg::QUO_W);

	state_t                                 state_q;
	spi_pkg::job_t                          job_q;
	logic [spi_pkg::REM_W-1:0]              rem_q;
	logic [spi_pkg::REM_W-1:0]              d2_q;
	logic [spi_pkg::REM_W-1:0]              dsh_q;
	logic                                   neg_q;
	logic                                   dzero_q;
	logic [spi_pkg::QUO_W-1:0]              quo_q;
	logic [STEP_W-1:0]                      step_q;
	logic signed [spi_pkg::DIFF_W-1:0]      diff_q;
	logic signed [spi_pkg::DELTA_W-1:0]     delta_q;
	logic [spi_pkg::POS_W-1:0]              pos_q;
	logic [spi_pkg::PROD_W-1:0]             fprod_q;
	logic signed [spi_pkg::APROD_W-1:0]     aprod_q;
	logic                                   out_valid_q;

	logic signed [spi_pkg::DIFF_W-1:0]      diff;
	logic signed [spi_pkg::DEN_W-1:0]       den;
	logic [spi_pkg::MAG_W-1:0]              abs_diff;
	logic [spi_pkg::DEN_W-1:0]              abs_den;
	logic [spi_pkg::REM_W-1:0]              n2;
	logic [spi_pkg::QUO_W-1:0]              quo_clamp;
	logic signed [spi_pkg::DELTA_W-1:0]     delta;
	logic signed [spi_pkg::POS_W:0]         pos_s;
	logic [spi_pkg::APROD_W-1:0]            abs_aprod;
	logic [spi_pkg::APROD_W-1:0]            amp_q_round;
	logic signed [spi_pkg::DEN_W-1:0]       amp_corr;
	logic signed [spi_pkg::DEN_W-1:0]       amp_s;
	logic [spi_pkg::AMP_W-1:0]              amp_sat;
	logic [spi_pkg::PROD_W-1:0]             freq_round;
	logic                                   out_free;

	assign diff     = $signed({1'b0, job_q.left}) - $signed({1'b0, job_q.right});
	assign den      = $signed({3'b000, job_q.left}) + $signed({3'b000, job_q.right})
		- $signed({2'b00, job_q.peak, 1'b0});
	assign abs_diff = diff[spi_pkg::DIFF_W-1] ? spi_pkg::MAG_W'(-diff)
		: spi_pkg::MAG_W'(diff);
	assign abs_den  = den[spi_pkg::DEN_W-1] ? spi_pkg::DEN_W'(-den) : spi_pkg::DEN_W'(den);
	assign n2       = spi_pkg::REM_W'({abs_diff, {spi_pkg::FRAC_W{1'b0}}})
		+ spi_pkg::REM_W'(abs_den);

	assign quo_clamp = (quo_q > spi_pkg::QUO_W'(spi_pkg::HALF_Q15))
		? spi_pkg::QUO_W'(spi_pkg::HALF_Q15) : quo_q;
	assign delta     = neg_q ? -$signed({1'b0, quo_clamp}) : $signed({1'b0, quo_clamp});
	assign pos_s     = $signed({1'b0, job_q.bin, {spi_pkg::FRAC_W{1'b0}}})
		+ (spi_pkg::POS_W+1)'(delta);

	assign abs_aprod   = aprod_q[spi_pkg::APROD_W-1] ? spi_pkg::APROD_W'(-aprod_q)
		: spi_pkg::APROD_W'(aprod_q);
	assign amp_q_round = (abs_aprod + spi_pkg::APROD_W'(1 << (spi_pkg::AMP_SHIFT - 1)))
		>> spi_pkg::AMP_SHIFT;
	assign amp_corr    = aprod_q[spi_pkg::APROD_W-1]
		? -$signed(spi_pkg::DEN_W'(amp_q_round)) : $signed(spi_pkg::DEN_W'(amp_q_round));
	assign amp_s       = $signed({3'b000, job_q.peak}) - amp_corr;
	always_comb begin
		if (amp_s < 0) begin
			amp_sat = '0;
		end else if (amp_s > $signed(spi_pkg::DEN_W'({spi_pkg::AMP_W{1'b1}}))) begin
			amp_sat = '1;
		end else begin
			amp_sat = spi_pkg::AMP_W'(amp_s);
		end
	end
	assign freq_round = (fprod_q + spi_pkg::PROD_W'(spi_pkg::HALF_Q15)) >> spi_pkg::FRAC_W;

	assign out_free  = !out_valid_q || out_ready;
	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			out_valid_q    <= 1'b0;
			job_q          <= '0;
			rem_q          <= '0;
			d2_q           <= '0;
			dsh_q          <= '0;
			neg_q          <= 1'b0;
			dzero_q        <= 1'b0;
			quo_q          <= '0;
			step_q         <= '0;
			diff_q         <= '0;
			delta_q        <= '0;
			pos_q          <= '0;
			fprod_q        <= '0;
			aprod_q        <= '0;
			found          <= 1'b0;
			peak_index     <= '0;
			peak_position  <= '0;
			peak_freq      <= '0;
			peak_amplitude <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						job_q   <= q_data;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					rem_q   <= n2;
					d2_q    <= spi_pkg::REM_W'({abs_den, 1'b0});
					neg_q   <= diff[spi_pkg::DIFF_W-1] ^ den[spi_pkg::DEN_W-1];
					dzero_q <= den == '0;
					diff_q  <= diff;
					quo_q   <= '0;
					state_q <= job_q.found ? S_CHECK : S_DONE;
				end
				S_CHECK: begin
					dsh_q  <= d2_q << (spi_pkg::QUO_W - 1);
					step_q <= STEP_W'(spi_pkg::QUO_W - 1);
					if (dzero_q) begin
						state_q <= S_POS;
					end else if (rem_q >= (d2_q << spi_pkg::QUO_W)) begin
						quo_q   <= spi_pkg::QUO_W'(spi_pkg::HALF_Q15);
						state_q <= S_POS;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						quo_q <= {quo_q[spi_pkg::QUO_W-2:0], 1'b1};
					end else begin
						quo_q <= {quo_q[spi_pkg::QUO_W-2:0], 1'b0};
					end
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= S_POS;
					end
				end
				S_POS: begin
					delta_q <= delta;
					pos_q   <= pos_s[spi_pkg::POS_W] ? '0 : spi_pkg::POS_W'(pos_s);
					state_q <= S_MUL;
				end
				S_MUL: begin
					fprod_q <= spi_pkg::PROD_W'(pos_q) * spi_pkg::PROD_W'(bin_spacing);
					aprod_q <= diff_q * delta_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						found       <= job_q.found;
						if (job_q.found) begin
							peak_index     <= job_q.bin;
							peak_position  <= pos_q;
							peak_freq      <= freq_round[spi_pkg::FREQ_W-1:0];
							peak_amplitude <= amp_sat;
						end else begin
							peak_index     <= '0;
							peak_position  <= '0;
							peak_freq      <= '0;
							peak_amplitude <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_delta_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (delta_q <= $signed(spi_pkg::DELTA_W'(spi_pkg::HALF_Q15))
			&& delta_q >= -$signed(spi_pkg::DELTA_W'(spi_pkg::HALF_Q15))))
		else $error("vertex offset out of range");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found) |-> (peak_index == '0 && peak_position == '0
			&& peak_freq == '0 && peak_amplitude == '0))
		else $error("short spectrum word not zero");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && $past(state_q) == S_CHECK)
			|-> (step_q == STEP_W'(spi_pkg::QUO_W - 1) && quo_q == '0))
		else $error("divider started in wrong state");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE))
		else $error("result dropped while output busy");

endmodule

/* sv/spectrum_peak_interpolator.sv */
// ----------------------------------------------------------------------------
// spectrum_peak_interpolator
// Parabolic peak interpolation over a streamed single-sided magnitude
// spectrum.
// ----------------------------------------------------------------------------
// Bins stream in at one word per cycle, bin 0 first, tlast on the final bin.
// The largest bin among bins 1 to second-to-last, and no later than bin
// 4095 (first wins on a tie), and its neighbors are kept; on the final bin
// one job is queued (two deep) and the interpolation engine returns one
// result word through its 15-step serial quotient divider, which is skipped
// on a zero denominator or an early saturated offset and for a short
// spectrum. A spectrum shorter than three bins returns found = 0 with zero
// fields. The input stalls while both queue entries are taken. bin_spacing
// may be written when idle.
// ----------------------------------------------------------------------------
module spectrum_peak_interpolator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [23:0]     s_axis_tdata,   // magnitude[23:0]
	input  logic            s_axis_tlast,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [119:0]    m_axis_tdata,   // peak_index, peak_position, peak_freq,
	                                        // peak_amplitude, zero fill
	output logic            m_axis_tuser,   // found
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [31:0]     cfg_data        // bin_spacing
);

	logic [spi_pkg::SPACING_W-1:0]  bin_spacing_q;
	logic                           accept;
	logic                           push;
	spi_pkg::job_t                  push_job;
	spi_pkg::job_t                  pop_job;
	logic                           pop;
	spi_pkg::q_status_t             q_status;
	logic [spi_pkg::IDX_W-1:0]      peak_index;
	logic [spi_pkg::POS_W-1:0]      peak_position;
	logic [spi_pkg::FREQ_W-1:0]     peak_freq;
	logic [spi_pkg::AMP_W-1:0]      peak_amplitude;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_status.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_spacing_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			bin_spacing_q <= cfg_data;
		end
	end

	spi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.magnitude (s_axis_tdata),
		.last      (s_axis_tlast),
		.push      (push),
		.job       (push_job)
	);

	spi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.pop_data  (pop_job),
		.status    (q_status)
	);

	spi_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_status.empty),
		.q_data         (pop_job),
		.q_pop          (pop),
		.bin_spacing    (bin_spacing_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.found          (m_axis_tuser),
		.peak_index     (peak_index),
		.peak_position  (peak_position),
		.peak_freq      (peak_freq),
		.peak_amplitude (peak_amplitude)
	);

	assign m_axis_tdata = {6'b000000, peak_amplitude, peak_freq, peak_position, peak_index};

endmodule
